>>> design/triangle_tangent_basis_core_macros.svh
// Assertion macros shared by the tangent basis design files.
`ifndef TRIANGLE_TANGENT_BASIS_CORE_MACROS_SVH
`define TRIANGLE_TANGENT_BASIS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TTB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define TTB_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define TTB_ASSERT_IMP(label, clk, rst_n, pre, post)
`define TTB_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> design/ttb_pkg.sv
package ttb_pkg;
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_CROSS,
        ST_DET,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_corner;
        logic start_cross;
        logic start_div;
        logic next_comp;
        logic clear_out;
    } t_cmd;

    typedef struct packed {
        logic cross_done;
        logic det_zero;
        logic div_done;
        logic last_comp;
    } t_status;
endpackage

>>> design/ttb_datapath.sv
`include "triangle_tangent_basis_core_macros.svh"
module ttb_datapath #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttb_pkg::t_cmd                 i_cmd,
    input  logic                          i_slot,
    output ttb_pkg::t_status              o_status,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_tex_u,
    input  logic signed [COORD_WIDTH-1:0] i_tex_v,
    output logic signed [COORD_WIDTH-1:0] o_res [6]
);
    import ttb_pkg::*;

    localparam int DW = COORD_WIDTH + 1;   // delta width
    localparam int PW = 2 * DW;            // product width
    localparam int NW = PW + 1;            // cross width
    localparam int SW = NW + FRAC_BITS;    // shifted magnitude width
    localparam int CW = $clog2(SW + 1);
    localparam logic [SW-1:0] MAXPOS = SW'((65'(1) << (COORD_WIDTH - 1)) - 65'(1));

    logic signed [COORD_WIDTH-1:0] r_hp [2][5];
    logic signed [DW-1:0] r_p1 [3];
    logic signed [DW-1:0] r_p2 [3];
    logic signed [DW-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [NW-1:0] r_num [6];
    logic signed [NW-1:0] r_det;
    logic [2:0]           r_step;
    logic [2:0]           r_comp;
    logic [SW-1:0]        r_rem, r_quo, r_den, r_nsh;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy, r_neg;
    logic signed [COORD_WIDTH-1:0] r_res [6];

    logic signed [COORD_WIDTH-1:0] in_v [5];
    logic signed [PW-1:0] prod_a, prod_b;
    logic signed [DW-1:0] ma, mb, mc, md;
    logic signed [NW-1:0] num_sel;
    logic [SW-1:0] n_rem_sh, sat_q, div_val;
    logic          trial_ok;

    assign in_v[0] = i_pos_x;
    assign in_v[1] = i_pos_y;
    assign in_v[2] = i_pos_z;
    assign in_v[3] = i_tex_u;
    assign in_v[4] = i_tex_v;

    // One cross-product term per cycle: seven terms over steps 0..6.
    always_comb begin
        ma = r_du1; mb = r_dv2; mc = r_dv1; md = r_du2;
        case (r_step)
            3'd0, 3'd1, 3'd2: begin
                ma = r_p1[r_step[1:0]]; mb = r_dv2; mc = r_p2[r_step[1:0]]; md = r_dv1;
            end
            3'd3, 3'd4, 3'd5: begin
                ma = r_p2[r_step[1:0] - 2'd3 + 2'd0]; mb = r_du1;
                mc = r_p1[r_step[1:0] - 2'd3 + 2'd0]; md = r_du2;
            end
            default: begin
                ma = r_du1; mb = r_dv2; mc = r_dv1; md = r_du2;
            end
        endcase
        prod_a = ma * mb;
        prod_b = mc * md;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_corner) begin
            for (int k = 0; k < 5; k++) r_hp[i_slot][k] <= in_v[k];
        end
        if (i_cmd.start_cross) begin
            for (int k = 0; k < 3; k++) begin
                r_p1[k] <= DW'(r_hp[1][k]) - DW'(r_hp[0][k]);
                r_p2[k] <= DW'(in_v[k]) - DW'(r_hp[0][k]);
            end
            r_du1 <= DW'(r_hp[1][3]) - DW'(r_hp[0][3]);
            r_dv1 <= DW'(r_hp[1][4]) - DW'(r_hp[0][4]);
            r_du2 <= DW'(i_tex_u) - DW'(r_hp[0][3]);
            r_dv2 <= DW'(i_tex_v) - DW'(r_hp[0][4]);
        end
        if (r_busy) begin
            if (r_step == 3'd6) r_det <= NW'(prod_a) - NW'(prod_b);
            else r_num[r_step] <= NW'(prod_a) - NW'(prod_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_cmd.start_cross) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd6) r_busy <= 1'b0;
        end
    end

    // Restoring division of |num| << FRAC_BITS by |det|, one bit per cycle.
    assign num_sel  = r_num[r_comp];
    assign n_rem_sh = {r_rem[SW-2:0], r_nsh[SW-1]};
    assign trial_ok = n_rem_sh >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_comp <= '0;
        end else begin
            if (i_cmd.clear_out) r_comp <= '0;
            else if (i_cmd.next_comp && r_comp != 3'd5) r_comp <= r_comp + 3'd1;
            if (i_cmd.start_div) r_cnt <= CW'(SW);
            else if (r_cnt != '0) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_neg <= num_sel[NW-1] ^ r_det[NW-1];
            r_nsh <= SW'(num_sel[NW-1] ? -num_sel : num_sel) << FRAC_BITS;
            r_den <= SW'(r_det[NW-1] ? -r_det : r_det);
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_nsh <= r_nsh << 1;
            r_rem <= trial_ok ? n_rem_sh - r_den : n_rem_sh;
            r_quo <= {r_quo[SW-2:0], trial_ok};
        end
    end

    always_comb begin
        if (!r_neg) sat_q = (r_quo > MAXPOS) ? MAXPOS : r_quo;
        else sat_q = (r_quo > MAXPOS + SW'(1)) ? MAXPOS + SW'(1) : r_quo;
        div_val = r_neg ? -sat_q : sat_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_out) begin
            for (int k = 0; k < 6; k++) r_res[k] <= '0;
        end else if (i_cmd.next_comp) begin
            r_res[r_comp] <= div_val[COORD_WIDTH-1:0];
        end
    end

    assign o_res = r_res;
    assign o_status.cross_done = r_busy && (r_step == 3'd6);
    assign o_status.det_zero   = (r_det == '0);
    assign o_status.div_done   = (r_cnt == '0);
    assign o_status.last_comp  = (r_comp == 3'd5);

    `TTB_ASSERT_NXT(a_div_counts, i_clk, i_rst_n, i_cmd.start_div, r_cnt == CW'(SW))
    `TTB_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, r_busy, r_cnt == '0)
    `TTB_ASSERT_IMP(a_comp_range, i_clk, i_rst_n, 1'b1, r_comp <= 3'd5)
endmodule

>>> design/ttb_ctrl.sv
`include "triangle_tangent_basis_core_macros.svh"
module ttb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_degenerate,
    output logic              o_slot,
    output ttb_pkg::t_cmd     o_cmd,
    input  ttb_pkg::t_status  i_status
);
    import ttb_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_count;
    logic r_degen;
    logic acc;

    assign acc = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: if (acc && r_count == 2'd2) n_state = ST_CROSS;
            ST_CROSS:   if (i_status.cross_done) n_state = ST_DET;
            ST_DET:     n_state = i_status.det_zero ? ST_OUT : ST_DIV;
            ST_DIV:     if (i_status.div_done) n_state = i_status.last_comp ? ST_OUT : ST_NEXT;
            ST_NEXT:    n_state = ST_DIV;
            ST_OUT:     if (!i_stall) n_state = ST_COLLECT;
            default:    n_state = ST_COLLECT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                o_stall = 1'b0;
                o_cmd.load_corner = acc && r_count != 2'd2;
                o_cmd.start_cross = acc && r_count == 2'd2;
                o_cmd.clear_out = acc && r_count == 2'd2;
            end
            ST_DET:  o_cmd.start_div = !i_status.det_zero;
            ST_DIV:  o_cmd.next_comp = i_status.div_done;
            ST_NEXT: o_cmd.start_div = 1'b1;
            ST_OUT:  o_valid = 1'b1;
            default: o_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_count <= '0;
            r_degen <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) r_count <= (r_count == 2'd2) ? 2'd0 : r_count + 2'd1;
            if (r_state == ST_DET) r_degen <= i_status.det_zero;
        end
    end

    assign o_slot = r_count[0];
    assign o_degenerate = r_degen;

    `TTB_ASSERT_IMP(a_count_ok, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `TTB_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `TTB_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != ST_COLLECT, o_stall)
endmodule

>>> design/triangle_tangent_basis_core.sv
// Throughput: corners are accepted one per cycle while collecting; once the third is
// taken, o_stall holds off the next triangle through the cross products, six serial
// restoring divisions running one quotient bit per cycle (skipped for a zero
// determinant) and the output handshake.
// Reset is synchronous and active low; it clears the corner count and state.
module triangle_tangent_basis_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_tex_u,
    input  logic signed [COORD_WIDTH-1:0] i_tex_v,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_tangent_x,
    output logic signed [COORD_WIDTH-1:0] o_tangent_y,
    output logic signed [COORD_WIDTH-1:0] o_tangent_z,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_x,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_y,
    output logic signed [COORD_WIDTH-1:0] o_bitangent_z,
    output logic                          o_degenerate
);
    import ttb_pkg::*;

    // The controller sequences corner capture, the cross products and the
    // divisions; the datapath holds corners, products and the divider.
    t_cmd    cmd;
    t_status status;
    logic    slot;
    logic signed [COORD_WIDTH-1:0] res [6];

    ttb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_degenerate,
        .o_slot(slot), .o_cmd(cmd), .i_status(status)
    );

    ttb_datapath #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_slot(slot), .o_status(status),
        .i_pos_x, .i_pos_y, .i_pos_z, .i_tex_u, .i_tex_v, .o_res(res)
    );

    // Results hold in the datapath until the request is taken.
    assign o_tangent_x   = res[0];
    assign o_tangent_y   = res[1];
    assign o_tangent_z   = res[2];
    assign o_bitangent_x = res[3];
    assign o_bitangent_y = res[4];
    assign o_bitangent_z = res[5];
endmodule
